// File: src/ltdv_pkg.sv
package ltdv_pkg;

    // Width of the program counter and of both encoded deltas.
    localparam int unsigned PcW   = 32;
    localparam int unsigned LineW = 16;

    // Varint byte layout: seven payload bits and one continuation bit.
    localparam int unsigned GroupW = 7;

    // One pair of deltas waiting to be turned into varint bytes.
    typedef struct packed {
        logic [PcW-1:0] pc_delta;
        logic [PcW-1:0] line_delta;
    } t_job;

    // Back-end serializer states.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_PC,
        BK_LINE
    } t_back_state;

endpackage

// File: src/ltdv_front.sv
module ltdv_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [ltdv_pkg::LineW-1:0]    i_line_number,
    input  logic                          i_end_of_file,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ltdv_pkg::PcW-1:0]      i_cfg_data,
    output logic                          o_job_push,
    output ltdv_pkg::t_job                o_job,
    input  logic                          i_job_full
);

    logic [ltdv_pkg::PcW-1:0]   r_start_pc,    n_start_pc;
    logic [ltdv_pkg::PcW-1:0]   r_current_pc,  n_current_pc;
    logic [ltdv_pkg::PcW-1:0]   r_previous_pc, n_previous_pc;
    logic [ltdv_pkg::LineW-1:0] r_previous_line, n_previous_line;
    logic                       accept;
    logic                       changed;

    // The register write is always taken; input items wait while it is offered.
    assign o_cfg_ready = 1'b1;

    // An item is taken whenever the job queue has room and no write is offered.
    assign full    = i_job_full || i_cfg_valid;
    assign accept  = push && !full;
    assign changed = (i_line_number != r_previous_line);

    // A changed line produces one job holding both deltas.
    assign o_job_push       = accept && changed;
    assign o_job.pc_delta   = r_current_pc - r_previous_pc;
    assign o_job.line_delta = {{(ltdv_pkg::PcW-ltdv_pkg::LineW){1'b0}}, i_line_number}
                            - {{(ltdv_pkg::PcW-ltdv_pkg::LineW){1'b0}}, r_previous_line};

    // Next values of the position state.
    always_comb begin
        n_start_pc      = r_start_pc;
        n_current_pc    = r_current_pc;
        n_previous_pc   = r_previous_pc;
        n_previous_line = r_previous_line;
        if (i_cfg_valid) begin
            n_start_pc   = i_cfg_data;
            n_current_pc = i_cfg_data;
        end else if (accept) begin
            if (i_end_of_file) begin
                n_current_pc    = r_start_pc;
                n_previous_pc   = '0;
                n_previous_line = '0;
            end else begin
                n_current_pc = r_current_pc + 1'b1;
                if (changed) begin
                    n_previous_pc   = r_current_pc;
                    n_previous_line = i_line_number;
                end
            end
        end
    end

    // Position state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_pc      <= '0;
            r_current_pc    <= '0;
            r_previous_pc   <= '0;
            r_previous_line <= '0;
        end else begin
            r_start_pc      <= n_start_pc;
            r_current_pc    <= n_current_pc;
            r_previous_pc   <= n_previous_pc;
            r_previous_line <= n_previous_line;
        end
    end

endmodule

// File: src/ltdv_job_queue.sv
module ltdv_job_queue #(
    parameter int unsigned Depth = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ltdv_pkg::t_job  i_job,
    output logic            o_full,
    input  logic            i_pop,
    output ltdv_pkg::t_job  o_job,
    output logic            o_empty
);

    localparam int unsigned PtrW = $clog2(Depth);
    localparam int unsigned CntW = $clog2(Depth + 1);

    ltdv_pkg::t_job  r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count,  n_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == CntW'(Depth));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    // Pointer and fill count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(Depth - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(Depth - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage needs no reset; entries are read only after being written.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// File: src/ltdv_back.sv
module ltdv_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ltdv_pkg::t_job  i_job,
    input  logic            i_job_empty,
    output logic            o_job_pop,
    output logic [7:0]      o_packed_byte,
    output logic            o_last_byte,
    output logic            empty,
    input  logic            pop
);

    ltdv_pkg::t_back_state    r_state, n_state;
    logic [ltdv_pkg::PcW-1:0] r_value, n_value;
    logic [ltdv_pkg::PcW-1:0] r_line_delta;
    logic [ltdv_pkg::PcW-1:0] rest;
    logic                     more;
    logic                     slot_free;
    logic                     emit;
    logic                     load;
    logic                     r_out_valid;
    logic [7:0]               r_out_byte;
    logic                     r_out_last;

    // The output register can take a byte when it is empty or being drained.
    assign slot_free = !r_out_valid || pop;
    assign rest      = r_value >> ltdv_pkg::GroupW;
    assign more      = (rest != '0);

    // Next-state logic of the serializer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ltdv_pkg::BK_IDLE: begin
                if (!i_job_empty) begin
                    n_state = ltdv_pkg::BK_PC;
                end
            end
            ltdv_pkg::BK_PC: begin
                if (slot_free && !more) begin
                    n_state = ltdv_pkg::BK_LINE;
                end
            end
            ltdv_pkg::BK_LINE: begin
                if (slot_free && !more) begin
                    n_state = ltdv_pkg::BK_IDLE;
                end
            end
            default: n_state = ltdv_pkg::BK_IDLE;
        endcase
    end

    // Output logic of the serializer.
    always_comb begin
        load    = 1'b0;
        emit    = 1'b0;
        n_value = r_value;
        unique case (r_state)
            ltdv_pkg::BK_IDLE: begin
                load    = !i_job_empty;
                n_value = i_job.pc_delta;
            end
            ltdv_pkg::BK_PC: begin
                emit    = slot_free;
                n_value = more ? rest : r_line_delta;
            end
            ltdv_pkg::BK_LINE: begin
                emit    = slot_free;
                n_value = rest;
            end
            default: begin
                load = 1'b0;
            end
        endcase
    end

    assign o_job_pop = load;

    // Serializer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ltdv_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load || emit) begin
            r_value <= n_value;
        end
        if (load) begin
            r_line_delta <= i_job.line_delta;
        end
    end

    // Output register holding the oldest waiting byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= {more, r_value[ltdv_pkg::GroupW-1:0]};
            r_out_last <= !more && (r_state == ltdv_pkg::BK_LINE);
        end
    end

    assign empty         = !r_out_valid;
    assign o_packed_byte = r_out_byte;
    assign o_last_byte   = r_out_last;

endmodule

// File: src/line_table_delta_varint_encoder.sv
// The first varint byte of a changed-line item passes through the job queue, the
// serializer load and the output register; then one byte follows per cycle while
// the receiver keeps popping. Throughput: one item per cycle is accepted while the
// job queue has room and no register write is offered; the serializer loads each
// job, then sends its bytes. Reset: synchronous and active low; it empties the job
// queue and output register, and zeroes start position, program counter and previous values.
module line_table_delta_varint_encoder #(
    parameter int unsigned JobDepth = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [ltdv_pkg::LineW-1:0]    i_line_number,
    input  logic                          i_end_of_file,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ltdv_pkg::PcW-1:0]      i_cfg_data,
    output logic                          empty,
    input  logic                          pop,
    output logic [7:0]                    o_packed_byte,
    output logic                          o_last_byte
);

    logic           job_push;
    logic           job_full;
    logic           job_pop;
    logic           job_empty;
    ltdv_pkg::t_job job_in;
    ltdv_pkg::t_job job_out;

    // Front end: tracks positions and classifies each item.
    ltdv_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_line_number (i_line_number),
        .i_end_of_file (i_end_of_file),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_job_push    (job_push),
        .o_job         (job_in),
        .i_job_full    (job_full)
    );

    // Queue of delta pairs between the two halves.
    ltdv_job_queue #(
        .Depth (JobDepth)
    ) u_job_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_job   (job_out),
        .o_empty (job_empty)
    );

    // Back end: turns each delta pair into varint bytes.
    ltdv_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (job_out),
        .i_job_empty   (job_empty),
        .o_job_pop     (job_pop),
        .o_packed_byte (o_packed_byte),
        .o_last_byte   (o_last_byte),
        .empty         (empty),
        .pop           (pop)
    );

endmodule

// File: tb/sv/tb_line_table_delta_varint_encoder.sv
module tb_line_table_delta_varint_encoder;

    timeunit 1ns;
    timeprecision 1ps;

    // Field widths taken from the design package.
    localparam int unsigned PcW    = ltdv_pkg::PcW;
    localparam int unsigned LineW  = ltdv_pkg::LineW;
    localparam int unsigned GroupW = ltdv_pkg::GroupW;

    // Varint byte layout and run limits.
    localparam logic [7:0] PayloadMask = 8'h7f;
    localparam logic [7:0] ContBit     = 8'h80;
    localparam int         DrainCycles = 8;
    localparam int         StallLimit  = 3000;
    localparam int         HoldCycles  = 150;

    // One varint byte that the encoder is expected to hand out.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_exp_byte;

    logic             i_clk          = 1'b0;
    logic             i_rst_n        = 1'b0;
    logic             push           = 1'b0;
    logic [LineW-1:0] i_line_number  = '0;
    logic             i_end_of_file  = 1'b0;
    logic             i_cfg_valid    = 1'b0;
    logic [PcW-1:0]   i_cfg_data     = '0;
    logic             pop            = 1'b0;
    logic             full;
    logic             o_cfg_ready;
    logic             empty;
    logic [7:0]       o_packed_byte;
    logic             o_last_byte;

    // Mirror of the encoder state, updated on every accepted item and write.
    logic [PcW-1:0]   file_start_pc = '0;
    logic [PcW-1:0]   cur_pc        = '0;
    logic [PcW-1:0]   prev_pc       = '0;
    logic [LineW-1:0] last_line     = '0;
    t_exp_byte        expected_bytes[$];
    t_exp_byte        want;

    int errors         = 0;
    int items_accepted = 0;
    int bytes_checked  = 0;
    int cfg_writes     = 0;
    int full_stalls    = 0;
    int idle_cycles    = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int rx_hold_left   = 0;
    int hold_requests  = 0;
    int hold_served    = 0;

    line_table_delta_varint_encoder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_line_number (i_line_number),
        .i_end_of_file (i_end_of_file),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .empty         (empty),
        .pop           (pop),
        .o_packed_byte (o_packed_byte),
        .o_last_byte   (o_last_byte)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Appends the LEB128 bytes of one value, low group first.
    function automatic void queue_varint(input logic [PcW-1:0] value);
        logic [PcW-1:0] rest;
        t_exp_byte      b;
        rest = value;
        do begin
            b.data = rest[7:0] & PayloadMask;
            b.last = 1'b0;
            rest   = rest >> GroupW;
            if (rest != '0) begin
                b.data = b.data | ContBit;
            end
            expected_bytes.push_back(b);
        end while (rest != '0);
    endfunction

    // Works out the bytes one line item causes and advances the mirrored state.
    function automatic void encode_line_item(input logic [LineW-1:0] line,
                                             input logic eof);
        t_exp_byte tail;
        if (line != last_line) begin
            queue_varint(cur_pc - prev_pc);
            queue_varint(PcW'(line) - PcW'(last_line));
            tail      = expected_bytes.pop_back();
            tail.last = 1'b1;
            expected_bytes.push_back(tail);
            prev_pc   = cur_pc;
            last_line = line;
        end
        cur_pc = cur_pc + 1'b1;
        if (eof) begin
            cur_pc    = file_start_pc;
            prev_pc   = '0;
            last_line = '0;
        end
    endfunction

    // Receiver: random pops, or a long hold-off counted down here once requested.
    always @(posedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served  <= hold_requests;
            rx_hold_left <= HoldCycles;
            pop          <= 1'b0;
        end else if (rx_hold_left > 0) begin
            pop          <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else begin
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: follows every handshake, checks each byte and watches for a hang.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                file_start_pc = i_cfg_data;
                cur_pc        = i_cfg_data;
                cfg_writes++;
            end
            if (push && full) begin
                full_stalls++;
            end
            if (push && !full) begin
                encode_line_item(i_line_number, i_end_of_file);
                items_accepted++;
            end
            if (pop && !empty) begin
                bytes_checked++;
                if (expected_bytes.size() == 0) begin
                    errors++;
                    $display("%0t: byte with nothing expected: expected none, actual %h last %b",
                             $time, o_packed_byte, o_last_byte);
                end else begin
                    want = expected_bytes.pop_front();
                    if (o_packed_byte !== want.data) begin
                        errors++;
                        $display("%0t: packed_byte mismatch: expected %h, actual %h",
                                 $time, want.data, o_packed_byte);
                    end
                    if (o_last_byte !== want.last) begin
                        errors++;
                        $display("%0t: last_byte mismatch: expected %b, actual %b",
                                 $time, want.last, o_last_byte);
                    end
                end
            end
            if ((i_cfg_valid && o_cfg_ready) || (push && !full) || (pop && !empty)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= StallLimit) begin
                    $display("%0t: no handshake for %0d cycles, %0d bytes still expected",
                             $time, idle_cycles, expected_bytes.size());
                    $display("Regression FAIL");
                    $finish;
                end
            end
        end
    end

    // Offers one line item and returns once it is accepted. Push stays high so
    // that back-to-back items need no gap; wait_idle lowers it.
    task automatic send_item(input logic [LineW-1:0] line, input logic eof);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push          <= 1'b1;
        i_line_number <= line;
        i_end_of_file <= eof;
        do @(posedge i_clk); while (full);
    endtask

    // Stops offering items and waits until every expected byte has come out.
    task automatic wait_idle();
        push <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    // Writes the start position; the caller makes sure the block is idle.
    task automatic write_start_position(input logic [PcW-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Field extremes, unchanged lines, negative deltas and end of file from reset.
    task automatic test_reset_defaults();
        send_item(16'h0000, 1'b0);
        send_item(16'h0001, 1'b0);
        send_item(16'h0001, 1'b0);
        send_item(16'hffff, 1'b0);
        send_item(16'h0000, 1'b0);
        send_item(16'h0080, 1'b0);
        send_item(16'h0080, 1'b1);
        send_item(16'h0000, 1'b1);
        send_item(16'h0007, 1'b1);
        wait_idle();
    endtask

    // Start position extremes, program counter wrap and a write in mid-file.
    task automatic test_start_position();
        write_start_position(32'hffff_ffff);
        send_item(16'h0003, 1'b0);
        send_item(16'h0003, 1'b0);
        send_item(16'h0004, 1'b0);
        send_item(16'h0004, 1'b1);
        wait_idle();
        write_start_position(32'h0000_007f);
        send_item(16'h0009, 1'b0);
        wait_idle();
        write_start_position(32'h0000_0080);
        send_item(16'h000a, 1'b0);
        send_item(16'h000a, 1'b1);
        wait_idle();
        write_start_position(32'h0000_0000);
        send_item(16'h0002, 1'b1);
        wait_idle();
    endtask

    // Random files: mostly small line steps and repeats, some jumps and extremes.
    task automatic test_random_traffic(input int count, input int tx_idle, input int rx_idle);
        logic [LineW-1:0] line;
        logic             eof;
        line          = '0;
        send_idle_pct = tx_idle;
        recv_idle_pct = rx_idle;
        case ($urandom_range(2))
            0: write_start_position(32'h0000_0000);
            1: write_start_position(32'hffff_fff0);
            default: write_start_position(PcW'($urandom()));
        endcase
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(9))
                0, 1, 2, 3: ;
                4, 5, 6: line = line + LineW'($urandom_range(0, 40)) - LineW'(20);
                7: line = LineW'($urandom());
                default: line = $urandom_range(1) ? 16'hffff : 16'h0000;
            endcase
            eof = ($urandom_range(11) == 0);
            send_item(line, eof);
            if (eof) begin
                line = '0;
            end
        end
        wait_idle();
    endtask

    // The receiver holds off for a long stretch while items keep coming,
    // so the job queue and the output register fill and the input stalls.
    task automatic test_output_backpressure();
        logic [LineW-1:0] line;
        line          = LineW'($urandom());
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests = hold_requests + 1;
        for (int i = 0; i < 24; i++) begin
            line = line + LineW'($urandom_range(1, 500));
            send_item(line, i == 23);
        end
        wait_idle();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_start_position();
        test_random_traffic(25, 23, 48);
        test_random_traffic(25, 48, 23);
        test_random_traffic(20, 0, 0);
        test_output_backpressure();
        wait_idle();

        $display("Covered %0d line items and %0d varint bytes over %0d start position writes,",
                 items_accepted, bytes_checked, cfg_writes);
        $display("with three idle mixes and a long output stall (%0d cycles of input held off).",
                 full_stalls);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/ltdv_pkg.sv
src/ltdv_front.sv
src/ltdv_job_queue.sv
src/ltdv_back.sv
src/line_table_delta_varint_encoder.sv
tb/sv/tb_line_table_delta_varint_encoder.sv
